@@ hw/rtl/assert_macros.svh @@
// Assertion shorthands for the pulse train channel; clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define TPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define TPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/tpt_pkg.sv @@
package tpt_pkg;

  localparam int unsigned NowBits   = 32;
  localparam int unsigned SpanBits  = 16;
  localparam int unsigned CountBits = 16;
  localparam int unsigned IdxBits   = 3;
  localparam int unsigned InBytes   = 5;
  localparam int unsigned OutBytes  = 1;

  // channel modes
  localparam logic [1:0] MODE_COUNTED = 2'd0;
  localparam logic [1:0] MODE_TOGGLE  = 2'd1;
  localparam logic [1:0] MODE_PASS    = 2'd2;
  localparam logic [1:0] MODE_FREE    = 2'd3;

  // register indexes
  localparam logic [IdxBits-1:0] REG_MODE     = 3'd0;
  localparam logic [IdxBits-1:0] REG_WIDTH    = 3'd1;
  localparam logic [IdxBits-1:0] REG_INTERVAL = 3'd2;
  localparam logic [IdxBits-1:0] REG_LIMIT    = 3'd3;
  localparam logic [IdxBits-1:0] REG_DEBOUNCE = 3'd4;

  localparam logic [SpanBits-1:0] WIDTH_RESET    = 16'd50;
  localparam logic [SpanBits-1:0] INTERVAL_RESET = 16'd500;
  localparam logic [SpanBits-1:0] DEBOUNCE_RESET = 16'd500;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SpanBits-1:0] width;
    logic [SpanBits-1:0] interval;
    logic [SpanBits-1:0] limit;
    logic [SpanBits-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic                 level;
    logic                 burst;
    logic [CountBits-1:0] done;
    logic                 free;
  } ctl_t;

endpackage

@@ hw/rtl/tpt_cfg.sv @@
module tpt_cfg
  import tpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IdxBits-1:0]  cfg_index,
  input  logic [SpanBits-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_COUNTED;
      cfg.width    <= WIDTH_RESET;
      cfg.interval <= INTERVAL_RESET;
      cfg.limit    <= '0;
      cfg.debounce <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     cfg.mode     <= cfg_data[1:0];
        REG_WIDTH:    cfg.width    <= cfg_data;
        REG_INTERVAL: cfg.interval <= cfg_data;
        REG_LIMIT:    cfg.limit    <= cfg_data;
        REG_DEBOUNCE: cfg.debounce <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/tpt_step.sv @@
module tpt_step
  import tpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  cfg_t                 cfg,
  input  ctl_t                 ctl,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] switch_time,
  input  logic                 trig,
  input  logic                 stop,
  input  logic [TIME_BITS-1:0] now,
  output ctl_t                 ctl_next,
  output logic [TIME_BITS-1:0] start_time_next,
  output logic [TIME_BITS-1:0] switch_time_next,
  output logic                 run
);

  logic [TIME_BITS-1:0] width_end;
  logic [TIME_BITS-1:0] interval_end;
  logic [TIME_BITS-1:0] debounce_end;
  logic                 width_done;
  logic                 interval_done;
  logic                 settled;
  logic [CountBits-1:0] done_inc;

  // sums wrap at the time width
  assign width_end     = start_time + TIME_BITS'(cfg.width);
  assign interval_end  = start_time + TIME_BITS'(cfg.interval);
  assign debounce_end  = switch_time + TIME_BITS'(cfg.debounce);
  assign width_done    = now >= width_end;
  assign interval_done = now >= interval_end;
  assign settled       = now >= debounce_end;
  assign done_inc      = ctl.done + CountBits'(1);

  always_comb begin
    ctl_next         = ctl;
    start_time_next  = start_time;
    switch_time_next = switch_time;
    run              = 1'b0;
    unique case (cfg.mode)
      MODE_COUNTED: begin
        if (stop) begin
          ctl_next.burst = 1'b0;
          ctl_next.level = 1'b0;
        end else if (trig && !ctl.burst) begin
          ctl_next.burst  = 1'b1;
          ctl_next.done   = '0;
          start_time_next = now;
          ctl_next.level  = 1'b1;
        end else if (!ctl.burst) begin
          ctl_next.level = 1'b0;
        end else if (ctl.level && width_done) begin
          ctl_next.level = 1'b0;
          if (cfg.limit == '0) begin
            ctl_next.done = '0;
          end else begin
            ctl_next.done = done_inc;
            if (done_inc >= cfg.limit) ctl_next.burst = 1'b0;
          end
        end else if (!ctl.level && interval_done) begin
          start_time_next = now;
          ctl_next.level  = 1'b1;
        end
        run = ctl_next.burst;
      end
      MODE_TOGGLE: begin
        if (stop) begin
          ctl_next.level = 1'b0;
        end else if (settled && trig) begin
          switch_time_next = now;
          ctl_next.level   = !ctl.level;
        end
      end
      MODE_PASS: begin
        ctl_next.level = trig && !stop;
      end
      MODE_FREE: begin
        if (stop) begin
          ctl_next.free  = 1'b0;
          ctl_next.level = 1'b0;
        end else if (!settled) begin
          ctl_next.level = ctl.level;
        end else if (trig) begin
          switch_time_next = now;
          if (ctl.free) begin
            ctl_next.free  = 1'b0;
            ctl_next.level = 1'b0;
          end else begin
            ctl_next.free   = 1'b1;
            start_time_next = now;
            ctl_next.level  = 1'b1;
          end
        end else if (ctl.free && ctl.level && width_done) begin
          ctl_next.level = 1'b0;
        end else if (ctl.free && !ctl.level && interval_done) begin
          start_time_next = now;
          ctl_next.level  = 1'b1;
        end
        run = ctl_next.free;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/triggered_pulse_train_channel.sv @@
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | trigger_level, stop_level, now_ms
// m_*      | out | m_tvalid/m_tready  | out_level, run_active
// cfg_*    | in  | cfg_we             | register index, 16-bit data
// One word per cycle sustained while m_tready stays high; each word passes
// through the input register, then the result register, before it is on m_*.
// A word's step is one pass of three time adds and compares on the state.
// rst is synchronous: registers return to their defaults, state to idle.
// A stall on m_tready holds the result and lets one more word into the
// input register before s_tready drops.
`include "assert_macros.svh"

module triggered_pulse_train_channel
  import tpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [8*InBytes-1:0]  s_tdata,  // trigger_level, stop_level, now_ms[31:0], pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [8*OutBytes-1:0] m_tdata,  // out_level, run_active, pad
  input  logic                  cfg_we,
  input  logic [IdxBits-1:0]    cfg_index,
  input  logic [SpanBits-1:0]   cfg_data
);

  cfg_t cfg;

  logic                 in_valid;
  logic                 in_trig;
  logic                 in_stop;
  logic [NowBits-1:0]   in_now;
  logic                 advance;

  ctl_t                 ctl;
  ctl_t                 ctl_next;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] start_time_next;
  logic [TIME_BITS-1:0] switch_time;
  logic [TIME_BITS-1:0] switch_time_next;
  logic                 run_next;

  logic                 out_valid;
  logic                 out_level;
  logic                 out_run;

  tpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_trig <= s_tdata[0];
      in_stop <= s_tdata[1];
      in_now  <= s_tdata[NowBits+1:2];
    end
  end

  tpt_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg              (cfg),
    .ctl              (ctl),
    .start_time       (start_time),
    .switch_time      (switch_time),
    .trig             (in_trig),
    .stop             (in_stop),
    .now              (TIME_BITS'(in_now)),
    .ctl_next         (ctl_next),
    .start_time_next  (start_time_next),
    .switch_time_next (switch_time_next),
    .run              (run_next)
  );

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl         <= '0;
      start_time  <= '0;
      switch_time <= '0;
    end else if (advance) begin
      ctl         <= ctl_next;
      start_time  <= start_time_next;
      switch_time <= switch_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level <= ctl_next.level;
      out_run   <= run_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(8*OutBytes-2){1'b0}}, out_run, out_level};

  `TPT_ASSERT_NEXT(a_stop_low, advance && in_stop, !out_level && !ctl.level,
                   "stop did not force the output low")
  `TPT_ASSERT_NEXT(a_pass_no_run, advance && cfg.mode == MODE_PASS, !out_run,
                   "run flag set in pass-through mode")
  `TPT_ASSERT_NEXT(a_level_tracks, advance, ctl.level == out_level,
                   "stored level differs from delivered level")
  `TPT_ASSERT(a_ready_room, !s_tready || !in_valid || advance,
              "input register overwritten while holding a word")

endmodule

@@ tb/sv/tb_triggered_pulse_train_channel.sv @@
module tb_triggered_pulse_train_channel;
  import tpt_pkg::*;

  class channel_board;
    logic [1:0]          mode;
    logic [SpanBits-1:0] width;
    logic [SpanBits-1:0] interval;
    logic [SpanBits-1:0] limit;
    logic [SpanBits-1:0] debounce;
    bit                  level;
    bit                  burst;
    bit                  free;
    bit [CountBits-1:0]  done;
    bit [NowBits-1:0]    pulse_t0;
    bit [NowBits-1:0]    switch_t;
    bit [1:0]            level_due[$];  // run_active, out_level
    int                  errors;

    function new();
      mode = MODE_COUNTED;
      width = WIDTH_RESET;
      interval = INTERVAL_RESET;
      limit = '0;
      debounce = DEBOUNCE_RESET;
      level = 0;
      burst = 0;
      free = 0;
      done = '0;
      pulse_t0 = '0;
      switch_t = '0;
      errors = 0;
    endfunction

    function void apply_reg(logic [IdxBits-1:0] idx, logic [SpanBits-1:0] data);
      case (idx)
        REG_MODE:     mode = data[1:0];
        REG_WIDTH:    width = data;
        REG_INTERVAL: interval = data;
        REG_LIMIT:    limit = data;
        REG_DEBOUNCE: debounce = data;
        default: ;
      endcase
    endfunction

    function bit reached(bit [NowBits-1:0] now, bit [NowBits-1:0] base,
                         bit [SpanBits-1:0] span);
      bit [NowBits-1:0] due_at;
      due_at = base + NowBits'(span);
      return now >= due_at;
    endfunction

    function void note_tick(logic [8*InBytes-1:0] word);
      bit               trig;
      bit               stop;
      bit [NowBits-1:0] now;
      bit               lvl;
      bit               run;
      trig = word[0];
      stop = word[1];
      now = word[NowBits+1:2];
      run = 0;
      case (mode)
        MODE_COUNTED: begin
          if (stop) begin
            burst = 0;
            lvl = 0;
          end else if (trig && !burst) begin
            burst = 1;
            done = '0;
            pulse_t0 = now;
            lvl = 1;
          end else if (!burst) begin
            lvl = 0;
          end else if (level && reached(now, pulse_t0, width)) begin
            done = done + 1'b1;
            if (limit == '0) done = '0;
            else if (done >= limit) burst = 0;
            lvl = 0;
          end else if (!level && reached(now, pulse_t0, interval)) begin
            pulse_t0 = now;
            lvl = 1;
          end else begin
            lvl = level;
          end
          run = burst;
        end
        MODE_TOGGLE: begin
          if (stop) lvl = 0;
          else if (!reached(now, switch_t, debounce)) lvl = level;
          else if (trig) begin
            switch_t = now;
            lvl = !level;
          end else lvl = level;
        end
        MODE_PASS: lvl = stop ? 1'b0 : trig;
        default: begin
          if (stop) begin
            free = 0;
            lvl = 0;
          end else if (!reached(now, switch_t, debounce)) begin
            lvl = level;
          end else if (trig) begin
            switch_t = now;
            if (free) begin
              free = 0;
              lvl = 0;
            end else begin
              free = 1;
              pulse_t0 = now;
              lvl = 1;
            end
          end else if (!free) begin
            lvl = level;
          end else if (level && reached(now, pulse_t0, width)) begin
            lvl = 0;
          end else if (!level && reached(now, pulse_t0, interval)) begin
            pulse_t0 = now;
            lvl = 1;
          end else begin
            lvl = level;
          end
          run = free;
        end
      endcase
      level = lvl;
      level_due.push_back({run, lvl});
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_word(logic [8*OutBytes-1:0] word);
      bit [1:0] due;
      if (level_due.size() == 0) begin
        report($sformatf("word %h with nothing outstanding", word));
        return;
      end
      due = level_due.pop_front();
      if (word[0] !== due[0])
        report($sformatf("out_level got %b want %b", word[0], due[0]));
      if (word[1] !== due[1])
        report($sformatf("run_active got %b want %b", word[1], due[1]));
    endtask

    function int pending();
      return level_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [8*InBytes-1:0]  s_tdata = '0;   // trigger_level, stop_level, now_ms[31:0], pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [8*OutBytes-1:0] m_tdata;        // out_level, run_active, pad
  logic                  cfg_we = 1'b0;
  logic [IdxBits-1:0]    cfg_index = '0;
  logic [SpanBits-1:0]   cfg_data = '0;

  channel_board     sb = new();
  int               src_idle_pct = 0;
  int               sink_idle_pct = 0;
  int               accepted_ticks = 0;
  int               stall_cycles = 0;
  bit               hold_rx = 1'b0;
  bit [NowBits-1:0] clock_ms = '0;
  logic [1:0]       mode_order[4] = '{MODE_COUNTED, MODE_TOGGLE, MODE_PASS, MODE_FREE};

  triggered_pulse_train_channel i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_tick(s_tdata);
        accepted_ticks++;
      end
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (hold_rx) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 3000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hold the sink off long enough to back up the input
  initial begin
    wait (accepted_ticks >= 1100);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (64) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic send_tick(bit trig, bit stop, bit [NowBits-1:0] now);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, now, stop, trig};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [IdxBits-1:0] idx, logic [SpanBits-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SpanBits-1:0] pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return SpanBits'($urandom);
    return SpanBits'($urandom_range(1, 12));
  endfunction

  initial begin
    bit               trig;
    bit               stop;
    int               r;
    logic [SpanBits-1:0] span;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // counted mode from reset values, a now value of all ones, stop beats trigger
    send_tick(1, 0, 0);
    send_tick(0, 0, 32'hFFFF_FFFF);
    send_tick(1, 1, 5);
    send_tick(1, 0, 6);
    send_tick(1, 0, 7);
    send_tick(0, 1, 8);
    settle();
    set_reg(REG_WIDTH, '0);
    set_reg(REG_INTERVAL, '0);
    set_reg(REG_LIMIT, 16'd1);
    send_tick(1, 0, 10);
    send_tick(0, 0, 10);
    send_tick(0, 0, 11);
    send_tick(0, 0, 12);
    settle();
    set_reg(REG_MODE, SpanBits'(MODE_TOGGLE));
    set_reg(REG_DEBOUNCE, '0);
    send_tick(1, 0, 20);
    send_tick(1, 0, 21);
    send_tick(1, 1, 22);
    send_tick(1, 0, 22);
    settle();
    set_reg(REG_DEBOUNCE, '1);
    send_tick(1, 0, 30);
    settle();
    set_reg(REG_MODE, {14'h3FFF, MODE_PASS});
    set_reg(REG_DEBOUNCE + 3'd3, '1);
    send_tick(1, 0, 31);
    send_tick(1, 1, 32);
    send_tick(0, 0, 33);
    settle();
    set_reg(REG_MODE, SpanBits'(MODE_FREE));
    set_reg(REG_DEBOUNCE, '0);
    send_tick(1, 0, 40);
    send_tick(0, 0, 41);
    send_tick(0, 0, 42);
    send_tick(1, 0, 43);
    send_tick(0, 1, 44);

    for (int ph = 0; ph < 12; ph++) begin
      src_idle_pct  = (ph < 4) ? 14 : (ph < 8) ? 66 : 0;
      sink_idle_pct = (ph < 4) ? 66 : (ph < 8) ? 14 : 0;
      settle();
      set_reg(REG_MODE, {14'($urandom), mode_order[ph % 4]});
      for (int k = 0; k < 4; k++) begin
        span = (ph == 0) ? '0 : (ph == 5) ? '1 : pick_span();
        if (k == 2 && ph != 5 && $urandom_range(0, 2) == 0) span = '0;
        set_reg(REG_WIDTH + IdxBits'(k), span);
      end
      if ($urandom_range(0, 2) == 0)
        set_reg(REG_DEBOUNCE + IdxBits'($urandom_range(1, 3)), SpanBits'($urandom));
      if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      repeat (121) begin
        r = $urandom_range(0, 99);
        if (r < 2) clock_ms = $urandom;
        else if (r < 6) clock_ms += $urandom_range(0, 70000);
        else clock_ms += $urandom_range(0, 3);
        trig = ($urandom_range(0, 99) < 15);
        stop = ($urandom_range(0, 99) < 3);
        send_tick(trig, stop, clock_ms);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tpt_pkg.sv
hw/rtl/tpt_cfg.sv
hw/rtl/tpt_step.sv
hw/rtl/triggered_pulse_train_channel.sv
tb/sv/tb_triggered_pulse_train_channel.sv
